@@ sv/modbus_rtu_request_framer_defines.svh @@
// Assertion macros for the Modbus RTU request framer.
`ifndef MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`ifndef SYNTH
`define MRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define MRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MRF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MRF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/mrf_pkg.sv @@
`timescale 1ns / 1ps
package mrf_pkg;

  localparam int COIL_COUNT_DEF      = 128;
  localparam int REG_COUNT_DEF       = 256;
  localparam int MAX_FRAME_REGS_DEF  = 16;
  localparam int MAX_FRAME_COILS_DEF = 128;

  localparam logic [1:0] CMD_COIL_WR = 2'd0;
  localparam logic [1:0] CMD_REG_WR  = 2'd1;
  localparam logic [1:0] CMD_SEND    = 2'd2;

  localparam logic [7:0] FC_READ_COILS  = 8'd1;
  localparam logic [7:0] FC_READ_INPUTS = 8'd2;
  localparam logic [7:0] FC_READ_HOLD   = 8'd3;
  localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0] FC_WRITE_REG   = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

  localparam logic [15:0] COIL_ON  = 16'hFF00;
  localparam logic [15:0] COIL_OFF = 16'h0000;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] base_addr;
    logic [15:0] count_or_value;
  } req_t;

  // CRC-16/MODBUS, one byte, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/mrf_ram.sv @@
`timescale 1ns / 1ps
module mrf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/mrf_seq.sv @@
`timescale 1ns / 1ps
module mrf_seq import mrf_pkg::*; #(
  parameter int COIL_COUNT      = COIL_COUNT_DEF,
  parameter int REG_COUNT       = REG_COUNT_DEF,
  parameter int MAX_FRAME_REGS  = MAX_FRAME_REGS_DEF,
  parameter int MAX_FRAME_COILS = MAX_FRAME_COILS_DEF,
  localparam int CAW = $clog2(COIL_COUNT),
  localparam int RAW = $clog2(REG_COUNT)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  req_t           req,
  output logic           busy,
  output logic           coil_re,
  output logic [CAW-1:0] coil_raddr,
  input  logic [0:0]     coil_rdata,
  output logic           reg_re,
  output logic [RAW-1:0] reg_raddr,
  input  logic [15:0]    reg_rdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);

  localparam int MAX_ITEMS = (MAX_FRAME_COILS > MAX_FRAME_REGS) ? MAX_FRAME_COILS
                                                               : MAX_FRAME_REGS;
  localparam int ITW = $clog2(MAX_ITEMS + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PREP   = 4'd1;
  localparam logic [3:0] ST_LATCH  = 4'd2;
  localparam logic [3:0] ST_HDR    = 4'd3;
  localparam logic [3:0] ST_RFETCH = 4'd4;
  localparam logic [3:0] ST_RHI    = 4'd5;
  localparam logic [3:0] ST_RLO    = 4'd6;
  localparam logic [3:0] ST_CRD    = 4'd7;
  localparam logic [3:0] ST_CACC   = 4'd8;
  localparam logic [3:0] ST_CEMIT  = 4'd9;
  localparam logic [3:0] ST_CRCL   = 4'd10;
  localparam logic [3:0] ST_CRCH   = 4'd11;

  logic [3:0]     st_r, st_nxt;
  req_t           req_r, req_nxt;
  logic [15:0]    word_r, word_nxt;
  logic [15:0]    crc_r, crc_nxt;
  logic [2:0]     bcnt_r, bcnt_nxt;
  logic [ITW-1:0] rem_r, rem_nxt;
  logic [2:0]     bp_r, bp_nxt;
  logic [7:0]     pack_r, pack_nxt;
  logic [CAW-1:0] caddr_r, caddr_nxt;
  logic [RAW-1:0] raddr_r, raddr_nxt;
  logic           ov_r, ov_nxt;
  logic [7:0]     od_r, od_nxt;
  logic           ol_r, ol_nxt;

  logic        load, emit, elast, ok;
  logic [7:0]  ebyte, hdr_byte, cbyte;
  logic [16:0] start_x, cnt_x, end_x, cnt_p7;
  logic        multi;

  assign load    = !ov_r || out_tready;
  assign start_x = {1'b0, req.base_addr};
  assign cnt_x   = {1'b0, req.count_or_value};
  assign end_x   = start_x + cnt_x;
  assign multi   = (req_r.function_code == FC_WRITE_COILS) ||
                   (req_r.function_code == FC_WRITE_REGS);
  assign cnt_p7  = {1'b0, word_r} + 17'd7;
  assign cbyte   = (req_r.function_code == FC_WRITE_COILS) ? cnt_p7[10:3]
                                                           : {word_r[6:0], 1'b0};

  always_comb begin
    case (req.function_code)
      FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLD: ok = 1'b1;
      FC_WRITE_COIL:  ok = (cnt_x == 17'd1) && (start_x < 17'(COIL_COUNT));
      FC_WRITE_REG:   ok = (cnt_x == 17'd1) && (start_x < 17'(REG_COUNT));
      FC_WRITE_COILS: ok = (cnt_x != 17'd0) && (cnt_x <= 17'(MAX_FRAME_COILS)) &&
                           (end_x <= 17'(COIL_COUNT));
      FC_WRITE_REGS:  ok = (cnt_x != 17'd0) && (cnt_x <= 17'(MAX_FRAME_REGS)) &&
                           (end_x <= 17'(REG_COUNT));
      default:        ok = 1'b0;
    endcase
  end

  always_comb begin
    case (bcnt_r)
      3'd0:    hdr_byte = req_r.slave_address;
      3'd1:    hdr_byte = req_r.function_code;
      3'd2:    hdr_byte = req_r.base_addr[15:8];
      3'd3:    hdr_byte = req_r.base_addr[7:0];
      3'd4:    hdr_byte = word_r[15:8];
      3'd5:    hdr_byte = word_r[7:0];
      default: hdr_byte = cbyte;
    endcase
  end

  always_comb begin
    st_nxt    = st_r;
    req_nxt   = req_r;
    word_nxt  = word_r;
    crc_nxt   = crc_r;
    bcnt_nxt  = bcnt_r;
    rem_nxt   = rem_r;
    bp_nxt    = bp_r;
    pack_nxt  = pack_r;
    caddr_nxt = caddr_r;
    raddr_nxt = raddr_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    ol_nxt    = ol_r;
    coil_re   = 1'b0;
    reg_re    = 1'b0;
    emit      = 1'b0;
    ebyte     = 8'h00;
    elast     = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = req;
          word_nxt  = req.count_or_value;
          crc_nxt   = CRC_INIT;
          bcnt_nxt  = 3'd0;
          rem_nxt   = req.count_or_value[ITW-1:0];
          bp_nxt    = 3'd0;
          pack_nxt  = 8'h00;
          caddr_nxt = req.base_addr[CAW-1:0];
          raddr_nxt = req.base_addr[RAW-1:0];
          if (ok) begin
            if ((req.function_code == FC_WRITE_COIL) ||
                (req.function_code == FC_WRITE_REG)) begin
              st_nxt = ST_PREP;
            end else begin
              st_nxt = ST_HDR;
            end
          end
        end
      end
      ST_PREP: begin
        coil_re = (req_r.function_code == FC_WRITE_COIL);
        reg_re  = (req_r.function_code != FC_WRITE_COIL);
        st_nxt  = ST_LATCH;
      end
      ST_LATCH: begin
        if (req_r.function_code == FC_WRITE_COIL) begin
          word_nxt = coil_rdata[0] ? COIL_ON : COIL_OFF;
        end else begin
          word_nxt = reg_rdata;
        end
        st_nxt = ST_HDR;
      end
      ST_HDR: begin
        emit  = 1'b1;
        ebyte = hdr_byte;
        if (load) begin
          bcnt_nxt = bcnt_r + 3'd1;
          if ((bcnt_r == 3'd5) && !multi) begin
            st_nxt = ST_CRCL;
          end else if (bcnt_r == 3'd6) begin
            st_nxt = (req_r.function_code == FC_WRITE_COILS) ? ST_CRD : ST_RFETCH;
          end
        end
      end
      ST_RFETCH: begin
        reg_re    = 1'b1;
        raddr_nxt = raddr_r + RAW'(1);
        st_nxt    = ST_RHI;
      end
      ST_RHI: begin
        emit  = 1'b1;
        ebyte = reg_rdata[15:8];
        if (load) begin
          st_nxt = ST_RLO;
        end
      end
      ST_RLO: begin
        emit  = 1'b1;
        ebyte = reg_rdata[7:0];
        if (load) begin
          if (rem_r == ITW'(1)) begin
            st_nxt = ST_CRCL;
          end else begin
            rem_nxt   = rem_r - ITW'(1);
            reg_re    = 1'b1;
            raddr_nxt = raddr_r + RAW'(1);
            st_nxt    = ST_RHI;
          end
        end
      end
      ST_CRD: begin
        coil_re   = 1'b1;
        caddr_nxt = caddr_r + CAW'(1);
        st_nxt    = ST_CACC;
      end
      ST_CACC: begin
        pack_nxt[bp_r] = coil_rdata[0];
        rem_nxt        = rem_r - ITW'(1);
        bp_nxt         = bp_r + 3'd1;
        if ((rem_r == ITW'(1)) || (bp_r == 3'd7)) begin
          st_nxt = ST_CEMIT;
        end else begin
          coil_re   = 1'b1;
          caddr_nxt = caddr_r + CAW'(1);
        end
      end
      ST_CEMIT: begin
        emit  = 1'b1;
        ebyte = pack_r;
        if (load) begin
          pack_nxt = 8'h00;
          st_nxt   = (rem_r == '0) ? ST_CRCL : ST_CRD;
        end
      end
      ST_CRCL: begin
        emit  = 1'b1;
        ebyte = crc_r[7:0];
        if (load) begin
          st_nxt = ST_CRCH;
        end
      end
      ST_CRCH: begin
        emit  = 1'b1;
        ebyte = crc_r[15:8];
        elast = 1'b1;
        if (load) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (emit && load) begin
      ov_nxt = 1'b1;
      od_nxt = ebyte;
      ol_nxt = elast;
      if ((st_r != ST_CRCL) && (st_r != ST_CRCH)) begin
        crc_nxt = crc_byte(crc_r, ebyte);
      end
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    word_r  <= word_nxt;
    crc_r   <= crc_nxt;
    bcnt_r  <= bcnt_nxt;
    rem_r   <= rem_nxt;
    bp_r    <= bp_nxt;
    pack_r  <= pack_nxt;
    caddr_r <= caddr_nxt;
    raddr_r <= raddr_nxt;
    od_r    <= od_nxt;
    ol_r    <= ol_nxt;
  end

  assign busy       = (st_r != ST_IDLE);
  assign coil_raddr = caddr_r;
  assign reg_raddr  = raddr_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule

@@ sv/modbus_rtu_request_framer.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Ports                           Carries
// in       input      in_tvalid/tready/tdata/tuser    table write or send request
// out      output     out_tvalid/tready/tdata/tlast   request frame bytes, wire order
//
// Send: functions 5 and 6 make one table read first; functions 15 and 16 make
// one table memory read per coil or register.
// Reset: a clearing pass over max(COIL_COUNT, REG_COUNT) addresses zeroes both tables.
// in_tready is low while clearing or framing; output back-pressure holds the sequencer,
// and a new transaction is taken once it is idle, even while the last byte waits.
`include "modbus_rtu_request_framer_defines.svh"
module modbus_rtu_request_framer import mrf_pkg::*; #(
  parameter int COIL_COUNT      = COIL_COUNT_DEF,
  parameter int REG_COUNT       = REG_COUNT_DEF,
  parameter int MAX_FRAME_REGS  = MAX_FRAME_REGS_DEF,
  parameter int MAX_FRAME_COILS = MAX_FRAME_COILS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // table_index[7:0], table_data[23:8], slave_address[31:24],
  // function_code[39:32], base_addr[55:40], count_or_value[71:56]
  input  logic [71:0] in_tdata,
  // command[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // frame_byte[7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  localparam int CAW       = $clog2(COIL_COUNT);
  localparam int RAW       = $clog2(REG_COUNT);
  localparam int CLR_DEPTH = (COIL_COUNT > REG_COUNT) ? COIL_COUNT : REG_COUNT;
  localparam int CLW       = $clog2(CLR_DEPTH);

  logic           clr_act_r, clr_act_nxt;
  logic [CLW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic           in_acc, seq_busy, seq_start;
  logic [1:0]     cmd;
  logic [7:0]     tidx;
  logic [15:0]    tdat;
  logic [31:0]    tidx32, clr32;
  req_t           req;

  logic           coil_we, reg_we, coil_re, reg_re;
  logic [CAW-1:0] coil_waddr, coil_raddr;
  logic [RAW-1:0] reg_waddr, reg_raddr;
  logic [0:0]     coil_wdata, coil_rdata;
  logic [15:0]    reg_wdata, reg_rdata;

  assign cmd  = in_tuser;
  assign tidx = in_tdata[7:0];
  assign tdat = in_tdata[23:8];
  assign req  = '{slave_address:  in_tdata[31:24],
                  function_code:  in_tdata[39:32],
                  base_addr:      in_tdata[55:40],
                  count_or_value: in_tdata[71:56]};

  assign in_tready = !clr_act_r && !seq_busy;
  assign in_acc    = in_tvalid && in_tready;
  assign seq_start = in_acc && (cmd == CMD_SEND);

  assign tidx32 = 32'(tidx);
  assign clr32  = 32'(clr_cnt_r);

  always_comb begin
    clr_act_nxt = clr_act_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_act_r) begin
      clr_cnt_nxt = clr_cnt_r + CLW'(1);
      if (clr32 == 32'(CLR_DEPTH - 1)) begin
        clr_act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      clr_act_r <= clr_act_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    if (clr_act_r) begin
      coil_we    = (clr32 < 32'(COIL_COUNT));
      coil_waddr = clr32[CAW-1:0];
      coil_wdata = 1'b0;
      reg_we     = (clr32 < 32'(REG_COUNT));
      reg_waddr  = clr32[RAW-1:0];
      reg_wdata  = 16'h0000;
    end else begin
      coil_we    = in_acc && (cmd == CMD_COIL_WR) && (tidx32 < 32'(COIL_COUNT));
      coil_waddr = tidx32[CAW-1:0];
      coil_wdata = tdat[0];
      reg_we     = in_acc && (cmd == CMD_REG_WR) && (tidx32 < 32'(REG_COUNT));
      reg_waddr  = tidx32[RAW-1:0];
      reg_wdata  = tdat;
    end
  end

  mrf_ram #(
    .WIDTH (1),
    .DEPTH (COIL_COUNT)
  ) u_coil_ram (
    .clk     (clk),
    .wr_en   (coil_we),
    .wr_addr (coil_waddr),
    .wr_data (coil_wdata),
    .rd_en   (coil_re),
    .rd_addr (coil_raddr),
    .rd_data (coil_rdata)
  );

  mrf_ram #(
    .WIDTH (16),
    .DEPTH (REG_COUNT)
  ) u_reg_ram (
    .clk     (clk),
    .wr_en   (reg_we),
    .wr_addr (reg_waddr),
    .wr_data (reg_wdata),
    .rd_en   (reg_re),
    .rd_addr (reg_raddr),
    .rd_data (reg_rdata)
  );

  mrf_seq #(
    .COIL_COUNT      (COIL_COUNT),
    .REG_COUNT       (REG_COUNT),
    .MAX_FRAME_REGS  (MAX_FRAME_REGS),
    .MAX_FRAME_COILS (MAX_FRAME_COILS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (seq_start),
    .req        (req),
    .busy       (seq_busy),
    .coil_re    (coil_re),
    .coil_raddr (coil_raddr),
    .coil_rdata (coil_rdata),
    .reg_re     (reg_re),
    .reg_raddr  (reg_raddr),
    .reg_rdata  (reg_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // tables are never written while a frame reads them
  `MRF_ASSERT_IMP(a_no_wr_busy, clk, rst_n, seq_busy, !coil_we && !reg_we)
  `MRF_ASSERT_IMP(a_rd_in_frame, clk, rst_n, coil_re || reg_re, seq_busy && !clr_act_r)
  `MRF_ASSERT_IMP(a_clr_quiet, clk, rst_n, clr_act_r, !out_tvalid && !seq_busy)
  `MRF_ASSERT_NXT(a_last_ends, clk, rst_n, out_tvalid && out_tready && out_tlast && !seq_busy, !out_tvalid)

endmodule
